FILE: hdl/ccsm_pkg.sv
// Shared types, constants and the CRC-8 step for the CRC-checked scratch memory slave.
package ccsm_pkg;

  // Scratch memory capacity in bytes (1 to 64).
  localparam int MEMORY_BYTES = 8;
  localparam int ADDR_W = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
  localparam int CNT_W = $clog2(MEMORY_BYTES + 1);
  localparam logic [7:0] MEM_BYTES_B = 8'(MEMORY_BYTES);
  localparam logic [CNT_W-1:0] SIZE_CAP = CNT_W'(MEMORY_BYTES);

  // Command bytes.
  localparam logic [7:0] CMD_READ = 8'hF0;
  localparam logic [7:0] CMD_WRITE = 8'h0F;
  localparam logic [7:0] CMD_BOTH = 8'hFF;

  // Dallas/Maxim CRC-8, reflected polynomial.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Command queue between parser and executor.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_CMD,
    PH_WSIZE,
    PH_WDATA,
    PH_WCRC,
    PH_RSIZE
  } phase_t;

  typedef enum logic [1:0] {
    AC_NONE,
    AC_READ,
    AC_WRITE,
    AC_BOTH
  } active_cmd_t;

  typedef enum logic [1:0] {
    OP_ERR,
    OP_STAGE,
    OP_COMMIT,
    OP_READ
  } op_kind_t;

  // One queued operation. count: staging address, or transfer size.
  // data: staged byte, or expected echo CRC for a commit.
  typedef struct packed {
    op_kind_t kind;
    logic [CNT_W-1:0] count;
    logic [7:0] data;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERR,
    BK_COPY_RD,
    BK_COPY_WR,
    BK_ECHO,
    BK_RD,
    BK_RDATA,
    BK_RCRC
  } back_state_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/ccsm_ram.sv
// Generic single-port-write, registered-read RAM.
module ccsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ccsm_front.sv
// Command parser: accepts received bytes and turns them into queued operations.
module ccsm_front
  import ccsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] bus_reset
  output logic       q_push,
  output op_t        q_op,
  input  logic       q_full
);

  phase_t           phase, phase_next;
  active_cmd_t      active_cmd, active_cmd_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] transfer_size, transfer_size_next;
  logic [7:0]       running_crc, running_crc_next;

  logic             in_fire;
  logic [CNT_W-1:0] size_clamped;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       crc_step;

  assign s_tready     = !q_full;
  assign in_fire      = s_tvalid && s_tready;
  assign size_clamped = (s_tdata > MEM_BYTES_B) ? SIZE_CAP : CNT_W'(s_tdata);
  assign count_inc    = byte_count + CNT_W'(1);
  assign crc_step     = crc8_update(running_crc, s_tdata);

  // Next state
  always_comb begin
    phase_next         = phase;
    active_cmd_next    = active_cmd;
    byte_count_next    = byte_count;
    transfer_size_next = transfer_size;
    running_crc_next   = running_crc;
    if (in_fire) begin
      if (s_tuser) begin
        phase_next         = PH_CMD;
        active_cmd_next    = AC_NONE;
        byte_count_next    = '0;
        transfer_size_next = '0;
        running_crc_next   = '0;
      end else begin
        case (phase)
          PH_CMD: begin
            if (s_tdata == CMD_READ) begin
              active_cmd_next = AC_READ;
              phase_next      = PH_RSIZE;
            end else if (s_tdata == CMD_WRITE) begin
              active_cmd_next = AC_WRITE;
              phase_next      = PH_WSIZE;
            end else if (s_tdata == CMD_BOTH) begin
              active_cmd_next = AC_BOTH;
              phase_next      = PH_WSIZE;
            end else begin
              active_cmd_next = AC_NONE;
            end
          end
          PH_WSIZE: begin
            transfer_size_next = size_clamped;
            byte_count_next    = '0;
            running_crc_next   = '0;
            phase_next         = (size_clamped == '0) ? PH_WCRC : PH_WDATA;
          end
          PH_WDATA: begin
            running_crc_next = crc_step;
            byte_count_next  = count_inc;
            if (count_inc >= transfer_size) begin
              phase_next = PH_WCRC;
            end
          end
          PH_WCRC: begin
            byte_count_next = '0;
            if (active_cmd == AC_BOTH) begin
              phase_next = PH_RSIZE;
            end else begin
              phase_next      = PH_CMD;
              active_cmd_next = AC_NONE;
            end
          end
          PH_RSIZE: begin
            transfer_size_next = size_clamped;
            running_crc_next   = '0;
            byte_count_next    = '0;
            phase_next         = PH_CMD;
            active_cmd_next    = AC_NONE;
          end
          default: begin
            phase_next      = PH_CMD;
            active_cmd_next = AC_NONE;
          end
        endcase
      end
    end
  end

  // Queue requests
  always_comb begin
    q_push     = 1'b0;
    q_op.kind  = OP_ERR;
    q_op.count = '0;
    q_op.data  = '0;
    if (in_fire && !s_tuser) begin
      case (phase)
        PH_CMD: begin
          if (s_tdata != CMD_READ && s_tdata != CMD_WRITE && s_tdata != CMD_BOTH) begin
            q_push = 1'b1;
          end
        end
        PH_WDATA: begin
          q_push     = 1'b1;
          q_op.kind  = OP_STAGE;
          q_op.count = byte_count;
          q_op.data  = s_tdata;
        end
        PH_WCRC: begin
          q_push     = (s_tdata == running_crc);
          q_op.kind  = OP_COMMIT;
          q_op.count = transfer_size;
          q_op.data  = running_crc;
        end
        PH_RSIZE: begin
          q_push     = 1'b1;
          q_op.kind  = OP_READ;
          q_op.count = size_clamped;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CMD;
      active_cmd    <= AC_NONE;
      byte_count    <= '0;
      transfer_size <= '0;
      running_crc   <= '0;
    end else begin
      phase         <= phase_next;
      active_cmd    <= active_cmd_next;
      byte_count    <= byte_count_next;
      transfer_size <= transfer_size_next;
      running_crc   <= running_crc_next;
    end
  end

endmodule

FILE: hdl/ccsm_fifo.sv
// Short operation queue between the parser and the executor.
module ccsm_fifo
  import ccsm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic empty,
  output op_t  head,
  input  logic pop
);

  op_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] fill;

  assign full  = (fill == Q_CW'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + Q_CW'(1);
        2'b01:   fill <= fill - Q_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/ccsm_back.sv
// Executor: stages, commits and reads scratch bytes and drives the response register.
module ccsm_back
  import ccsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  op_t        q_head,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] tx_byte
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser    // [0] unknown_command
);

  back_state_t       state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cur_size;
  logic [7:0]        cur_crc;
  logic [MEMORY_BYTES-1:0] stored_valid;

  logic [ADDR_W-1:0] cnt_addr;
  logic              out_free;
  logic [7:0]        stage_rdata, store_rdata, rd_byte;

  logic              stage_we, store_we, load_out;
  logic [7:0]        out_byte;
  logic              out_last, out_unk;

  assign cnt_addr = cnt[ADDR_W-1:0];
  assign out_free = !m_tvalid || m_tready;
  // Entries never committed read as the reset value, zero.
  assign rd_byte  = stored_valid[cnt_addr] ? store_rdata : 8'h00;

  ccsm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_staging (
    .clk   (clk),
    .we    (stage_we),
    .waddr (q_head.count[ADDR_W-1:0]),
    .wdata (q_head.data),
    .raddr (cnt_addr),
    .rdata (stage_rdata)
  );

  ccsm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_stored (
    .clk   (clk),
    .we    (store_we),
    .waddr (cnt_addr),
    .wdata (stage_rdata),
    .raddr (cnt_addr),
    .rdata (store_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            OP_ERR:    state_next = BK_ERR;
            OP_STAGE:  state_next = BK_IDLE;
            OP_COMMIT: state_next = BK_COPY_RD;
            OP_READ:   state_next = BK_RD;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_ERR:     if (out_free) state_next = BK_IDLE;
      BK_COPY_RD: state_next = (cnt == cur_size) ? BK_ECHO : BK_COPY_WR;
      BK_COPY_WR: state_next = BK_COPY_RD;
      BK_ECHO:    if (out_free) state_next = BK_IDLE;
      BK_RD:      state_next = (cnt == cur_size) ? BK_RCRC : BK_RDATA;
      BK_RDATA:   if (out_free) state_next = BK_RD;
      BK_RCRC:    if (out_free) state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop    = 1'b0;
    stage_we = 1'b0;
    store_we = 1'b0;
    load_out = 1'b0;
    out_byte = 8'h00;
    out_last = 1'b0;
    out_unk  = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop    = !q_empty;
        stage_we = !q_empty && (q_head.kind == OP_STAGE);
      end
      BK_ERR: begin
        load_out = out_free;
        out_last = 1'b1;
        out_unk  = 1'b1;
      end
      BK_COPY_WR: begin
        store_we = 1'b1;
      end
      BK_ECHO, BK_RCRC: begin
        load_out = out_free;
        out_byte = cur_crc;
        out_last = 1'b1;
      end
      BK_RDATA: begin
        load_out = out_free;
        out_byte = rd_byte;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      stored_valid <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (store_we) begin
        stored_valid[cnt_addr] <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_size <= q_head.count;
      cur_crc  <= (q_head.kind == OP_COMMIT) ? q_head.data : 8'h00;
      cnt      <= '0;
    end else if (store_we) begin
      cnt <= cnt + CNT_W'(1);
    end else if (load_out && state == BK_RDATA) begin
      cur_crc <= crc8_update(cur_crc, rd_byte);
      cnt     <= cnt + CNT_W'(1);
    end
    if (load_out) begin
      m_tdata <= out_byte;
      m_tlast <= out_last;
      m_tuser <= out_unk;
    end
  end

`ifndef ASSERT_OFF
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
    else $error("error response must be a single zero byte marked last");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_COPY_WR || state == BK_RDATA) |-> (cnt < cur_size))
    else $error("transfer index beyond size");
`endif

endmodule

FILE: hdl/crc_checked_scratch_memory_slave_top.sv
// Top level of the CRC-checked scratch memory slave.
//
// Byte-serial memory slave. Each request on the s_ side is one byte from the
// bus master (rx_byte in s_tdata) or a bus reset (s_tuser high, byte ignored,
// transaction aborted, scratch contents kept). Command 0xF0 reads: a size
// byte follows and the slave returns that many scratch bytes from address 0
// plus their CRC-8. Command 0x0F writes: size, data bytes, then CRC-8; on a
// match the data is committed from address 0 and the CRC is echoed, on a
// mismatch nothing is returned. Command 0xFF is a write followed by a read.
// Sizes above MEMORY_BYTES are clamped. Any other command gives one response
// with m_tuser high and m_tdata zero. The CRC echo of a write, the CRC that
// ends a read and the error response each carry m_tlast. CRC is Dallas/Maxim
// CRC-8 (poly 0x8C reflected, init 0). Rate: the parser takes one request per
// cycle while its four-entry operation queue has room. The executor behind it
// handles one operation at a time, taking the next only when idle. It stages
// each data byte as it takes it from the queue; a commit copies each byte by a
// staging RAM read and a scratch RAM write, then sends the echo; a read does
// one scratch RAM read and one output register load per byte, then sends the
// CRC; output register loads wait out any stall on the m_ side.
// The scratch memory reads as zero after reset; no clearing pass is needed.
module crc_checked_scratch_memory_slave_top
  import ccsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] bus_reset
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] tx_byte
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser    // [0] unknown_command
);

  // Parser -> queue
  logic q_push;
  op_t  q_in;
  logic q_full;

  // Queue -> executor
  logic q_empty;
  op_t  q_head;
  logic q_pop;

  // Front: protocol parsing and write-data CRC.
  ccsm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (q_push),
    .q_op     (q_in),
    .q_full   (q_full)
  );

  // Decouples request intake from response generation.
  ccsm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head),
    .pop     (q_pop)
  );

  // Back: staging/scratch memories, commit copy, read-out and response register.
  ccsm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
